FILE: hdl/ordered_list_push_remove_defines.svh
// assertion macros shared by the ordered list modules
// expects clk_i and rst_ni in the scope of each use
`ifndef ORDERED_LIST_PUSH_REMOVE_DEFINES_SVH
`define ORDERED_LIST_PUSH_REMOVE_DEFINES_SVH

// property that holds at every clock edge outside reset
`define OLPR_ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// consequent that holds in the cycle after the antecedent
`define OLPR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/olpr_pkg.sv
// shared types and constants of the ordered list block
// no dependencies
`default_nettype none

package olpr_pkg;

  localparam int unsigned ListDepthDef = 16;
  localparam int unsigned CountOutW    = 5;

  typedef enum logic [1:0] {
    ModeInsert      = 2'd0,
    ModeRemoveValue = 2'd1,
    ModeRemoveFront = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    StDone    = 2'd0,
    StMissing = 2'd1,
    StFull    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SIdle,
    SExec,
    SScan,
    SShift
  } state_e;

  typedef enum logic [1:0] {
    RdOff0,
    RdOff1,
    RdOff2
  } rd_off_e;

  typedef enum logic {
    WrFront,
    WrIdx
  } wr_sel_e;

  typedef struct packed {
    logic    load;
    logic    idx_clr;
    logic    idx_inc;
    logic    rd_en;
    rd_off_e rd_off;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    head_inc;
    logic    head_dec;
    logic    cnt_inc;
    logic    cnt_dec;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic match;
    logic last;
    logic last2;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: hdl/ordered_list_push_remove.sv
// top level of the ordered list: controller plus datapath
// depends on olpr_pkg, olpr_ctrl and olpr_dp
//
// Usage: drive mode_i and value_i with start high; the item is taken at a
// rising edge where start is high and busy is low. busy stays high while
// the item is worked on. Each item yields one result: done_o is high for
// exactly one cycle with status_o and entry_count_o valid in that cycle.
// The receiver cannot stall, so the result transfer is that single cycle;
// busy is already low then, so the next item may be taken at that edge.
// After the accepting edge the item is worked on in the SExec state, and
// done_o is registered from the state in which the item ends; insert,
// remove-front, any empty-list remove and the unused mode end in SExec. A
// remove by value walks the list through the entry memory (registered read,
// separate write port), one entry per cycle for the search and one per cycle to close the gap.
// Entries live in a circular buffer, so inserts and front removals move
// only the head pointer. entry_count_o holds the count after the item,
// modulo 32.
// Reset clears the count and the head pointer: the list starts empty.
// The entry memory is not cleared; only written entries are ever read.
`default_nettype none

module ordered_list_push_remove #(
  parameter int unsigned LIST_DEPTH = olpr_pkg::ListDepthDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic        [1:0]                     mode_i,
  input  logic signed [31:0]                    value_i,
  output logic                                  done_o,
  output logic        [1:0]                     status_o,
  output logic        [olpr_pkg::CountOutW-1:0] entry_count_o
);
  import olpr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  status_e  status;

  olpr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .mode_i   (mode_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o),
    .status_o (status)
  );

  olpr_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .entry_count_o (entry_count_o)
  );

  assign status_o = status;

endmodule

`default_nettype wire

FILE: hdl/olpr_dp.sv
// datapath: circular entry memory, head pointer, count and scan index
// depends on olpr_pkg and ordered_list_push_remove_defines.svh
`default_nettype none
`include "ordered_list_push_remove_defines.svh"

module olpr_dp #(
  parameter int unsigned LIST_DEPTH = olpr_pkg::ListDepthDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic signed [31:0]                    value_i,
  input  olpr_pkg::dp_cmd_t                     cmd_i,
  output olpr_pkg::dp_stat_t                    stat_o,
  output logic        [olpr_pkg::CountOutW-1:0] entry_count_o
);
  import olpr_pkg::*;

  localparam int unsigned AW = $clog2(LIST_DEPTH);
  localparam int unsigned CW = ($clog2(LIST_DEPTH + 1) > CountOutW) ?
                               $clog2(LIST_DEPTH + 1) : CountOutW;

  logic [31:0]   mem [LIST_DEPTH];
  logic [31:0]   value_q;
  logic [31:0]   rd_q;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] rd_log;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic [AW-1:0] head_prev;
  logic [AW-1:0] head_next;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] lidx);
    logic [CW:0] s;
    s = {{(CW + 1 - AW){1'b0}}, head} + {1'b0, lidx};
    if (s >= (CW + 1)'(LIST_DEPTH)) begin
      s = s - (CW + 1)'(LIST_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign head_prev = (head_q == '0) ? AW'(LIST_DEPTH - 1) : head_q - AW'(1);
  assign head_next = (head_q == AW'(LIST_DEPTH - 1)) ? '0 : head_q + AW'(1);

  always_comb begin
    case (cmd_i.rd_off)
      RdOff0:  rd_log = idx_q;
      RdOff1:  rd_log = idx_q + CW'(1);
      RdOff2:  rd_log = idx_q + CW'(2);
      default: rd_log = idx_q;
    endcase
  end

  assign rd_addr = phys(head_q, rd_log);

  always_comb begin
    case (cmd_i.wr_sel)
      WrFront: begin
        wr_addr = head_prev;
        wr_data = value_q;
      end
      WrIdx: begin
        wr_addr = phys(head_q, idx_q);
        wr_data = rd_q;
      end
      default: begin
        wr_addr = head_prev;
        wr_data = value_q;
      end
    endcase
  end

  always_comb begin
    head_d = head_q;
    if (cmd_i.head_dec) begin
      head_d = head_prev;
    end else if (cmd_i.head_inc) begin
      head_d = head_next;
    end
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
      idx_q  <= '0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign stat_o.empty  = (cnt_q == '0);
  assign stat_o.full   = (cnt_q == CW'(LIST_DEPTH));
  assign stat_o.match  = (rd_q == value_q);
  assign stat_o.last   = (idx_q + CW'(1) == cnt_q);
  assign stat_o.last2  = (idx_q + CW'(2) == cnt_q);

  assign entry_count_o = cnt_q[CountOutW-1:0];

  `OLPR_ASSERT_ALWAYS(a_cnt_range, cnt_q <= CW'(LIST_DEPTH), "entry count above depth")
  `OLPR_ASSERT_ALWAYS(a_no_overfill, !(cmd_i.cnt_inc && stat_o.full), "insert into full list")
  `OLPR_ASSERT_ALWAYS(a_no_underflow, !(cmd_i.cnt_dec && stat_o.empty), "remove from empty list")

endmodule

`default_nettype wire

FILE: hdl/olpr_ctrl.sv
// controller: sequences insert, remove-front and search-and-close-gap
// depends on olpr_pkg and ordered_list_push_remove_defines.svh
`default_nettype none
`include "ordered_list_push_remove_defines.svh"

module olpr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [1:0]           mode_i,
  input  olpr_pkg::dp_stat_t   stat_i,
  output olpr_pkg::dp_cmd_t    cmd_o,
  output logic                 busy_o,
  output logic                 done_o,
  output olpr_pkg::status_e    status_o
);
  import olpr_pkg::*;

  state_e  state_q, state_d;
  mode_e   mode_q;
  logic    done_q;
  status_e status_q;
  logic    accept;
  logic    fin;
  status_e fin_status;

  assign accept = start_i && (state_q == SIdle);

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          state_d = SExec;
        end
      end
      SExec: begin
        if (mode_q == ModeRemoveValue && !stat_i.empty) begin
          state_d = SScan;
        end else begin
          state_d = SIdle;
        end
      end
      SScan: begin
        if (stat_i.last) begin
          state_d = SIdle;
        end else if (stat_i.match) begin
          state_d = SShift;
        end
      end
      SShift: begin
        if (stat_i.last2) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    fin        = 1'b0;
    fin_status = StDone;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          cmd_o.load    = 1'b1;
          cmd_o.idx_clr = 1'b1;
        end
      end
      SExec: begin
        case (mode_q)
          ModeInsert: begin
            fin = 1'b1;
            if (stat_i.full) begin
              fin_status = StFull;
            end else begin
              cmd_o.wr_en    = 1'b1;
              cmd_o.wr_sel   = WrFront;
              cmd_o.head_dec = 1'b1;
              cmd_o.cnt_inc  = 1'b1;
            end
          end
          ModeRemoveFront: begin
            fin = 1'b1;
            if (stat_i.empty) begin
              fin_status = StMissing;
            end else begin
              cmd_o.head_inc = 1'b1;
              cmd_o.cnt_dec  = 1'b1;
            end
          end
          ModeRemoveValue: begin
            if (stat_i.empty) begin
              fin        = 1'b1;
              fin_status = StMissing;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_off = RdOff0;
            end
          end
          default: fin = 1'b1;
        endcase
      end
      SScan: begin
        if (stat_i.match) begin
          if (stat_i.last) begin
            fin           = 1'b1;
            cmd_o.cnt_dec = 1'b1;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_off = RdOff1;
          end
        end else if (stat_i.last) begin
          fin        = 1'b1;
          fin_status = StMissing;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_off  = RdOff1;
          cmd_o.idx_inc = 1'b1;
        end
      end
      SShift: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WrIdx;
        cmd_o.idx_inc = 1'b1;
        if (stat_i.last2) begin
          fin           = 1'b1;
          cmd_o.cnt_dec = 1'b1;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_off = RdOff2;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      mode_q   <= ModeInsert;
      done_q   <= 1'b0;
      status_q <= StDone;
    end else begin
      state_q <= state_d;
      done_q  <= fin;
      if (accept) begin
        mode_q <= mode_e'(mode_i);
      end
      if (fin) begin
        status_q <= fin_status;
      end
    end
  end

  assign busy_o   = (state_q != SIdle);
  assign done_o   = done_q;
  assign status_o = status_q;

  `OLPR_ASSERT_ALWAYS(a_done_idle, !done_q || state_q == SIdle, "result while busy")
  `OLPR_ASSERT_NEXT(a_accept_exec, accept, state_q == SExec && !done_q, "accept not executed")
  `OLPR_ASSERT_NEXT(a_full_insert, fin && fin_status == StFull, mode_q == ModeInsert,
                    "full status outside insert")

endmodule

`default_nettype wire
